>>> hdl/assert_macros.svh
// assertion helpers shared by tns_ring and tabu_neighbor_selector_core
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tns_pkg.sv
// shared types, widths and codes for the tabu neighbour selector
// used by tns_ring and tabu_neighbor_selector_core
`default_nettype none

package tns_pkg;

    localparam int RING_AW = 6;
    localparam int DEPTH_W = 7;
    localparam int FIT_W   = 31;
    localparam int HASH_W  = 32;
    localparam int SUM_W   = 41;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int STS_W   = 3;
    localparam int ACT_W   = 2;
    localparam int ITER_W  = 32;

    localparam logic [DEPTH_W-1:0] TABU_DEPTH    = 7'd64;
    localparam logic [CNT_W-1:0]   MAX_NEIGHBORS = 11'd1024;
    localparam logic [FIT_W-1:0]   FIT_ONES      = 31'h7FFF_FFFF;

    localparam logic [ACT_W-1:0] ACT_NEIGHBOR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FALLBACK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART  = 2'd2;

    localparam logic [STS_W-1:0] STS_RECORDED     = 3'd0;
    localparam logic [STS_W-1:0] STS_ACCEPTED     = 3'd1;
    localparam logic [STS_W-1:0] STS_FB_NEEDED    = 3'd2;
    localparam logic [STS_W-1:0] STS_FB_ACCEPTED  = 3'd3;
    localparam logic [STS_W-1:0] STS_RESTARTED    = 3'd4;

    typedef struct packed {
        logic                start;
        logic [DEPTH_W-1:0]  len;
        logic [HASH_W-1:0]   key;
        logic                wr_en;
        logic [RING_AW-1:0]  wr_addr;
        logic [HASH_W-1:0]   wr_data;
    } t_ring_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_ring_stat;

    // depth register clamped to 1..TABU_DEPTH
    function automatic logic [DEPTH_W-1:0] active_depth(input logic [DEPTH_W-1:0] d);
        logic [DEPTH_W-1:0] r;
        r = d;
        if (d == '0) r = {{(DEPTH_W-1){1'b0}}, 1'b1};
        if (d > TABU_DEPTH) r = TABU_DEPTH;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tns_ring.sv
// ring of forbidden hashes: one-port memory, sequential lookup, one read a cycle
// depends on tns_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tns_ring (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tns_pkg::t_ring_ctl i_ctl,
    output tns_pkg::t_ring_stat     o_stat
);

    logic [tns_pkg::HASH_W-1:0]  mem [tns_pkg::TABU_DEPTH];
    logic [tns_pkg::HASH_W-1:0]  r_q;
    logic                        r_busy;
    logic                        r_rd_valid;
    logic                        r_hit;
    logic [tns_pkg::DEPTH_W-1:0] r_issue;
    logic [tns_pkg::DEPTH_W-1:0] r_len;
    logic [tns_pkg::HASH_W-1:0]  r_key;
    logic                        w_rd_en;
    logic                        w_done;

    assign w_rd_en = r_busy && (r_issue < r_len);
    // last read compared once its data has come back
    assign w_done  = r_busy && (r_issue == r_len) && !r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (w_rd_en) begin
            r_q <= mem[r_issue[tns_pkg::RING_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_issue    <= '0;
            r_len      <= '0;
        end else if (i_ctl.start) begin
            r_busy     <= 1'b1;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_issue    <= '0;
            r_len      <= i_ctl.len;
            r_key      <= i_ctl.key;
        end else if (r_busy) begin
            if (r_rd_valid && (r_q == r_key)) begin
                r_hit <= 1'b1;
            end
            r_rd_valid <= w_rd_en;
            if (w_rd_en) begin
                r_issue <= r_issue + 1'b1;
            end
            if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.done = w_done;
    assign o_stat.hit  = r_hit;

    `CHK_IMPL(a_start_idle, i_ctl.start, !r_busy, "ring lookup started while busy")
    `CHK_IMPL(a_write_idle, i_ctl.wr_en, !r_busy && !i_ctl.start, "ring write during lookup")
    `CHK_NEXT(a_start_busy, i_ctl.start, r_busy, "ring lookup did not begin")

endmodule

`default_nettype wire

>>> hdl/tabu_neighbor_selector_core.sv
// tabu neighbour selector top level: round statistics, candidate choice, ring update
// depends on tns_pkg, tns_ring and assert_macros.svh
//
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   action, fitness, solution_hash, end_of_round
//  out       from block o_out_valid / i_out_stall status .. iteration (one per item)
//  cfg       to block   i_cfg_we                  forbidden_depth
//
// a neighbour or fallback item goes through the start, wait and update states; in wait the
// first n = min(ring fill, clamped forbidden_depth) ring entries are scanned one entry a cycle
// restart and unused actions skip the scan and go from idle straight to the update state
// the next transfer can be taken in the cycle after the result is written; items go one at a time
// the ring needs no clearing pass: a fill count bounds the lookup, so reset is immediate
// input stalls while an item is in work; a result still waiting holds the next one at its update
`default_nettype none
`include "assert_macros.svh"

module tabu_neighbor_selector_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tns_pkg::DEPTH_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [tns_pkg::ACT_W-1:0]   i_action,
    input  wire logic [tns_pkg::FIT_W-1:0]   i_fitness,
    input  wire logic [tns_pkg::HASH_W-1:0]  i_solution_hash,
    input  wire logic                        i_end_of_round,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [tns_pkg::STS_W-1:0]        o_status,
    output logic                             o_neighbor_is_tabu,
    output logic [tns_pkg::IDX_W-1:0]        o_candidate_index,
    output logic [tns_pkg::FIT_W-1:0]        o_round_best,
    output logic [tns_pkg::FIT_W-1:0]        o_round_worst,
    output logic [tns_pkg::SUM_W-1:0]        o_round_sum,
    output logic [tns_pkg::CNT_W-1:0]        o_round_count,
    output logic [tns_pkg::FIT_W-1:0]        o_best_ever,
    output logic                             o_improved,
    output logic [tns_pkg::ITER_W-1:0]       o_iteration
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] r_state;

    // latched item
    logic [tns_pkg::ACT_W-1:0]  r_act;
    logic [tns_pkg::FIT_W-1:0]  r_fit;
    logic [tns_pkg::HASH_W-1:0] r_hash;
    logic                       r_eor;

    // configuration and search state
    logic [tns_pkg::DEPTH_W-1:0] r_depth;
    logic [tns_pkg::DEPTH_W-1:0] r_fill,      n_fill;
    logic [tns_pkg::RING_AW-1:0] r_pos,       n_pos;
    logic                        r_cand_valid, n_cand_valid;
    logic [tns_pkg::FIT_W-1:0]   r_cand_fit,  n_cand_fit;
    logic [tns_pkg::HASH_W-1:0]  r_cand_hash, n_cand_hash;
    logic [tns_pkg::IDX_W-1:0]   r_cand_pos,  n_cand_pos;
    logic [tns_pkg::FIT_W-1:0]   r_min,       n_min;
    logic [tns_pkg::FIT_W-1:0]   r_max,       n_max;
    logic [tns_pkg::SUM_W-1:0]   r_sum,       n_sum;
    logic [tns_pkg::CNT_W-1:0]   r_cnt,       n_cnt;
    logic [tns_pkg::FIT_W-1:0]   r_best,      n_best;
    logic [tns_pkg::ITER_W-1:0]  r_iter,      n_iter;
    logic                        r_await,     n_await;

    // result register
    logic                        r_out_valid;
    logic [tns_pkg::STS_W-1:0]   r_o_status,  n_o_status;
    logic                        r_o_tabu,    n_o_tabu;
    logic [tns_pkg::IDX_W-1:0]   r_o_idx,     n_o_idx;
    logic [tns_pkg::FIT_W-1:0]   r_o_best,    n_o_best;
    logic [tns_pkg::FIT_W-1:0]   r_o_worst,   n_o_worst;
    logic [tns_pkg::SUM_W-1:0]   r_o_sum,     n_o_sum;
    logic [tns_pkg::CNT_W-1:0]   r_o_cnt,     n_o_cnt;
    logic                        r_o_imp,     n_o_imp;

    logic                        w_in_xfer;
    logic                        w_commit;
    logic                        w_mv_en;
    logic [tns_pkg::FIT_W-1:0]   w_mv_fit;
    logic [tns_pkg::HASH_W-1:0]  w_mv_hash;
    logic                        w_clear;
    logic [tns_pkg::DEPTH_W-1:0] w_depth;
    logic [tns_pkg::DEPTH_W-1:0] w_fill_inc;
    logic [tns_pkg::DEPTH_W-1:0] w_pos_inc;
    logic                        w_scan;

    tns_pkg::t_ring_ctl  w_ctl;
    tns_pkg::t_ring_stat w_stat;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_commit   = (r_state == S_UPDATE) && (!r_out_valid || !i_out_stall);
    assign w_depth    = tns_pkg::active_depth(r_depth);
    assign w_fill_inc = r_fill + 1'b1;
    assign w_pos_inc  = {1'b0, r_pos} + 1'b1;
    assign w_scan     = (i_action == tns_pkg::ACT_NEIGHBOR) ||
                        (i_action == tns_pkg::ACT_FALLBACK);

    assign w_ctl.start   = (r_state == S_START);
    assign w_ctl.len     = (r_fill < w_depth) ? r_fill : w_depth;
    assign w_ctl.key     = r_hash;
    assign w_ctl.wr_en   = w_commit && w_mv_en;
    assign w_ctl.wr_addr = r_pos;
    assign w_ctl.wr_data = w_mv_hash;

    tns_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_cand_valid = r_cand_valid;
        n_cand_fit   = r_cand_fit;
        n_cand_hash  = r_cand_hash;
        n_cand_pos   = r_cand_pos;
        n_min        = r_min;
        n_max        = r_max;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_best       = r_best;
        n_iter       = r_iter;
        n_await      = r_await;
        n_o_status   = tns_pkg::STS_RECORDED;
        n_o_tabu     = 1'b0;
        n_o_idx      = '0;
        n_o_imp      = 1'b0;
        w_mv_en      = 1'b0;
        w_mv_fit     = r_fit;
        w_mv_hash    = r_hash;
        w_clear      = 1'b0;

        case (r_act)
            tns_pkg::ACT_NEIGHBOR: begin
                // a neighbour while a fallback is pending starts a fresh round
                if (r_await) begin
                    n_cand_valid = 1'b0;
                    n_cand_fit   = tns_pkg::FIT_ONES;
                    n_cand_hash  = '0;
                    n_cand_pos   = '0;
                    n_min        = tns_pkg::FIT_ONES;
                    n_max        = '0;
                    n_sum        = '0;
                    n_cnt        = '0;
                end
                n_await  = 1'b0;
                n_o_tabu = w_stat.hit;
                if (n_cnt < tns_pkg::MAX_NEIGHBORS) begin
                    if (!w_stat.hit && (!n_cand_valid || (r_fit < n_cand_fit))) begin
                        n_cand_valid = 1'b1;
                        n_cand_fit   = r_fit;
                        n_cand_hash  = r_hash;
                        n_cand_pos   = n_cnt[tns_pkg::IDX_W-1:0];
                    end
                    n_sum = n_sum + {{(tns_pkg::SUM_W-tns_pkg::FIT_W){1'b0}}, r_fit};
                    if (r_fit < n_min) n_min = r_fit;
                    if (r_fit > n_max) n_max = r_fit;
                    n_cnt = n_cnt + 1'b1;
                end
                if (r_eor) begin
                    if (n_cand_valid) begin
                        w_mv_en    = 1'b1;
                        w_mv_fit   = n_cand_fit;
                        w_mv_hash  = n_cand_hash;
                        n_o_status = tns_pkg::STS_ACCEPTED;
                        n_o_idx    = n_cand_pos;
                        w_clear    = 1'b1;
                    end else begin
                        n_o_status = tns_pkg::STS_FB_NEEDED;
                        n_await    = 1'b1;
                    end
                end
            end
            tns_pkg::ACT_FALLBACK: begin
                n_o_tabu = w_stat.hit;
                if (r_await) begin
                    w_mv_en    = 1'b1;
                    n_await    = 1'b0;
                    n_o_status = tns_pkg::STS_FB_ACCEPTED;
                    w_clear    = 1'b1;
                end
            end
            tns_pkg::ACT_RESTART: begin
                n_fill       = '0;
                n_pos        = '0;
                n_cand_valid = 1'b0;
                n_cand_fit   = tns_pkg::FIT_ONES;
                n_cand_hash  = '0;
                n_cand_pos   = '0;
                n_min        = tns_pkg::FIT_ONES;
                n_max        = '0;
                n_sum        = '0;
                n_cnt        = '0;
                n_best       = r_fit;
                n_iter       = '0;
                n_await      = 1'b0;
                n_o_status   = tns_pkg::STS_RESTARTED;
            end
            default: begin
            end
        endcase

        // the accepted move goes into the ring at the write position
        if (w_mv_en) begin
            n_fill = (w_fill_inc < w_depth) ? w_fill_inc : w_depth;
            n_pos  = (w_pos_inc >= w_depth) ? '0 : w_pos_inc[tns_pkg::RING_AW-1:0];
            if (w_mv_fit < n_best) begin
                n_best  = w_mv_fit;
                n_o_imp = 1'b1;
            end
            n_iter = r_iter + 1'b1;
        end

        n_o_best  = n_min;
        n_o_worst = n_max;
        n_o_sum   = n_sum;
        n_o_cnt   = n_cnt;

        if (w_clear) begin
            n_cand_valid = 1'b0;
            n_cand_fit   = tns_pkg::FIT_ONES;
            n_cand_hash  = '0;
            n_cand_pos   = '0;
            n_min        = tns_pkg::FIT_ONES;
            n_max        = '0;
            n_sum        = '0;
            n_cnt        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= tns_pkg::TABU_DEPTH;
            r_fill      <= '0;
            r_pos       <= '0;
            r_cand_valid <= 1'b0;
            r_cand_fit  <= tns_pkg::FIT_ONES;
            r_cand_hash <= '0;
            r_cand_pos  <= '0;
            r_min       <= tns_pkg::FIT_ONES;
            r_max       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_best      <= tns_pkg::FIT_ONES;
            r_iter      <= '0;
            r_await     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= w_scan ? S_START : S_UPDATE;
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_stat.done) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_fill       <= n_fill;
                r_pos        <= n_pos;
                r_cand_valid <= n_cand_valid;
                r_cand_fit   <= n_cand_fit;
                r_cand_hash  <= n_cand_hash;
                r_cand_pos   <= n_cand_pos;
                r_min        <= n_min;
                r_max        <= n_max;
                r_sum        <= n_sum;
                r_cnt        <= n_cnt;
                r_best       <= n_best;
                r_iter       <= n_iter;
                r_await      <= n_await;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_act  <= i_action;
            r_fit  <= i_fitness;
            r_hash <= i_solution_hash;
            r_eor  <= i_end_of_round;
        end
        if (w_commit) begin
            r_o_status <= n_o_status;
            r_o_tabu   <= n_o_tabu;
            r_o_idx    <= n_o_idx;
            r_o_best   <= n_o_best;
            r_o_worst  <= n_o_worst;
            r_o_sum    <= n_o_sum;
            r_o_cnt    <= n_o_cnt;
            r_o_imp    <= n_o_imp;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_neighbor_is_tabu = r_o_tabu;
    assign o_candidate_index  = r_o_idx;
    assign o_round_best       = r_o_best;
    assign o_round_worst      = r_o_worst;
    assign o_round_sum        = r_o_sum;
    assign o_round_count      = r_o_cnt;
    assign o_best_ever        = r_best;
    assign o_improved         = r_o_imp;
    assign o_iteration        = r_iter;

    `CHK_IMPL(a_await_nocand, r_await, !r_cand_valid, "fallback pending with a candidate held")
    `CHK_IMPL(a_done_in_wait, w_stat.done, r_state == S_WAIT, "ring lookup ended outside wait")
    `CHK_IMPL(a_fill_bound, 1'b1, r_fill <= tns_pkg::TABU_DEPTH, "ring fill beyond depth")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// testbench for tabu_neighbor_selector_core: directed and random neighbour traffic,
// checked transfer by transfer against a predictor of the selector kept in this file
// depends on tns_pkg and the rtl top level only
`timescale 1ns / 100ps

module tb_top;

    localparam logic [tns_pkg::ACT_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [tns_pkg::FIT_W-1:0]  FIT_TOP    = 31'h7FFF_FFFE;
    localparam logic [tns_pkg::HASH_W-1:0] WARM_KEY   = 32'h7E00_0000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int POOL_SIZE   = 6;
    localparam int BURST_LEN   = 24;

    typedef struct packed {
        logic [tns_pkg::ACT_W-1:0]  action;
        logic [tns_pkg::FIT_W-1:0]  fitness;
        logic [tns_pkg::HASH_W-1:0] hash;
        logic                       eor;
    } t_neighbor;

    typedef struct packed {
        logic [tns_pkg::STS_W-1:0]  status;
        logic                       tabu;
        logic [tns_pkg::IDX_W-1:0]  index;
        logic [tns_pkg::FIT_W-1:0]  best;
        logic [tns_pkg::FIT_W-1:0]  worst;
        logic [tns_pkg::SUM_W-1:0]  sum;
        logic [tns_pkg::CNT_W-1:0]  count;
        logic [tns_pkg::FIT_W-1:0]  best_ever;
        logic                       improved;
        logic [tns_pkg::ITER_W-1:0] iteration;
    } t_outcome;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [tns_pkg::DEPTH_W-1:0]  cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic [tns_pkg::ACT_W-1:0]    action = '0;
    logic [tns_pkg::FIT_W-1:0]    fitness = '0;
    logic [tns_pkg::HASH_W-1:0]   solution_hash = '0;
    logic                         end_of_round = 1'b0;
    logic                         out_stall = 1'b0;
    wire                          in_stall;
    wire                          out_valid;
    wire [tns_pkg::STS_W-1:0]     status;
    wire                          neighbor_is_tabu;
    wire [tns_pkg::IDX_W-1:0]     candidate_index;
    wire [tns_pkg::FIT_W-1:0]     round_best;
    wire [tns_pkg::FIT_W-1:0]     round_worst;
    wire [tns_pkg::SUM_W-1:0]     round_sum;
    wire [tns_pkg::CNT_W-1:0]     round_count;
    wire [tns_pkg::FIT_W-1:0]     best_ever;
    wire                          improved;
    wire [tns_pkg::ITER_W-1:0]    iteration;

    tabu_neighbor_selector_core u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_action           (action),
        .i_fitness          (fitness),
        .i_solution_hash    (solution_hash),
        .i_end_of_round     (end_of_round),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_neighbor_is_tabu (neighbor_is_tabu),
        .o_candidate_index  (candidate_index),
        .o_round_best       (round_best),
        .o_round_worst      (round_worst),
        .o_round_sum        (round_sum),
        .o_round_count      (round_count),
        .o_best_ever        (best_ever),
        .o_improved         (improved),
        .o_iteration        (iteration)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    t_neighbor                  pending_neighbors [$];
    t_outcome                   due_outcomes [$];
    logic [tns_pkg::HASH_W-1:0] recent_hashes [$];
    t_neighbor                  next_neighbor;
    t_outcome                   observed;
    t_outcome                   due;
    logic              in_taken = 1'b0;
    logic              steady = 1'b0;
    int                queued_count = 0;
    int                accepted_count = 0;
    int                result_count = 0;
    int                mismatch_count = 0;
    int                tabu_hits = 0;
    int                improvements = 0;
    int                status_tally [8];
    int                cycle_count = 0;
    int                hold_trigger = 0;
    int                hold_seen = 0;
    int                hold_left = 0;

    // selector model state
    logic [tns_pkg::HASH_W-1:0]  ring_mem [tns_pkg::TABU_DEPTH];
    logic [tns_pkg::DEPTH_W-1:0] ring_fill;
    logic [tns_pkg::RING_AW-1:0] ring_wpos;
    logic [tns_pkg::DEPTH_W-1:0] depth_reg;
    logic [tns_pkg::FIT_W-1:0]   cand_fit;
    logic [tns_pkg::HASH_W-1:0]  cand_key;
    logic [tns_pkg::IDX_W-1:0]   cand_pos;
    logic                        cand_ok;
    logic [tns_pkg::FIT_W-1:0]   min_fit;
    logic [tns_pkg::FIT_W-1:0]   max_fit;
    logic [41:0]                 fit_total;
    logic [tns_pkg::CNT_W-1:0]   seen_count;
    logic [tns_pkg::FIT_W-1:0]   best_fit;
    logic [tns_pkg::ITER_W-1:0]  iter_count;
    logic                        awaiting_fallback;

    function automatic logic [tns_pkg::DEPTH_W-1:0] ring_span();
        logic [tns_pkg::DEPTH_W-1:0] d;
        d = depth_reg;
        if (d == '0) d = 7'd1;
        if (d > tns_pkg::TABU_DEPTH) d = tns_pkg::TABU_DEPTH;
        return d;
    endfunction

    function automatic logic ring_hit(input logic [tns_pkg::HASH_W-1:0] h);
        int n;
        logic found;
        n = int'((ring_fill < ring_span()) ? ring_fill : ring_span());
        found = 1'b0;
        for (int i = 0; i < n; i++)
            if (ring_mem[i] == h) found = 1'b1;
        return found;
    endfunction

    function automatic void clear_round();
        cand_fit   = tns_pkg::FIT_ONES;
        cand_key   = '0;
        cand_pos   = '0;
        cand_ok    = 1'b0;
        min_fit    = tns_pkg::FIT_ONES;
        max_fit    = '0;
        fit_total  = '0;
        seen_count = '0;
    endfunction

    // commit a move: ring insert, best-ever update, iteration step
    function automatic logic take_move(input logic [tns_pkg::FIT_W-1:0] fit,
                                       input logic [tns_pkg::HASH_W-1:0] h);
        logic [tns_pkg::DEPTH_W-1:0] d;
        logic lowered;
        d = ring_span();
        ring_mem[ring_wpos] = h;
        ring_fill = (ring_fill + 7'd1 < d) ? ring_fill + 7'd1 : d;
        ring_wpos = ({1'b0, ring_wpos} + 7'd1 >= d) ? '0 : ring_wpos + 6'd1;
        lowered = 1'b0;
        if (fit < best_fit) begin
            best_fit = fit;
            lowered = 1'b1;
        end
        iter_count = iter_count + 32'd1;
        return lowered;
    endfunction

    function automatic void selector_reset();
        foreach (ring_mem[i]) ring_mem[i] = '0;
        ring_fill = '0;
        ring_wpos = '0;
        clear_round();
        best_fit = tns_pkg::FIT_ONES;
        iter_count = '0;
        awaiting_fallback = 1'b0;
        depth_reg = tns_pkg::TABU_DEPTH;
    endfunction

    function automatic t_outcome predict_selection(input t_neighbor nb);
        t_outcome o;
        logic clear_after;
        o = '0;
        o.status = tns_pkg::STS_RECORDED;
        clear_after = 1'b0;
        case (nb.action)
            tns_pkg::ACT_NEIGHBOR: begin
                if (awaiting_fallback) begin
                    awaiting_fallback = 1'b0;
                    clear_round();
                end
                o.tabu = ring_hit(nb.hash);
                if (seen_count < tns_pkg::MAX_NEIGHBORS) begin
                    if (!o.tabu && (!cand_ok || nb.fitness < cand_fit)) begin
                        cand_ok  = 1'b1;
                        cand_fit = nb.fitness;
                        cand_key = nb.hash;
                        cand_pos = seen_count[tns_pkg::IDX_W-1:0];
                    end
                    fit_total = fit_total + {11'd0, nb.fitness};
                    if (nb.fitness < min_fit) min_fit = nb.fitness;
                    if (nb.fitness > max_fit) max_fit = nb.fitness;
                    seen_count = seen_count + 11'd1;
                end
                if (nb.eor) begin
                    if (cand_ok) begin
                        o.improved = take_move(cand_fit, cand_key);
                        o.status = tns_pkg::STS_ACCEPTED;
                        o.index = cand_pos;
                        clear_after = 1'b1;
                    end else begin
                        o.status = tns_pkg::STS_FB_NEEDED;
                        awaiting_fallback = 1'b1;
                    end
                end
            end
            tns_pkg::ACT_FALLBACK: begin
                o.tabu = ring_hit(nb.hash);
                if (awaiting_fallback) begin
                    o.improved = take_move(nb.fitness, nb.hash);
                    awaiting_fallback = 1'b0;
                    o.status = tns_pkg::STS_FB_ACCEPTED;
                    clear_after = 1'b1;
                end
            end
            tns_pkg::ACT_RESTART: begin
                ring_fill = '0;
                ring_wpos = '0;
                clear_round();
                best_fit = nb.fitness;
                iter_count = '0;
                awaiting_fallback = 1'b0;
                o.status = tns_pkg::STS_RESTARTED;
            end
            default: ;
        endcase
        o.best      = min_fit;
        o.worst     = max_fit;
        o.sum       = fit_total[tns_pkg::SUM_W-1:0];
        o.count     = seen_count;
        o.best_ever = best_fit;
        o.iteration = iter_count;
        if (clear_after) clear_round();
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %0s", $time, result_count, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input t_outcome got, input t_outcome want);
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.tabu !== want.tabu)
            report_mismatch($sformatf("tabu flag %0b, want %0b", got.tabu, want.tabu));
        if (got.index !== want.index)
            report_mismatch($sformatf("index %0d, want %0d", got.index, want.index));
        if (got.best !== want.best)
            report_mismatch($sformatf("round best %0h, want %0h", got.best, want.best));
        if (got.worst !== want.worst)
            report_mismatch($sformatf("round worst %0h, want %0h", got.worst, want.worst));
        if (got.sum !== want.sum)
            report_mismatch($sformatf("round sum %0h, want %0h", got.sum, want.sum));
        if (got.count !== want.count)
            report_mismatch($sformatf("round count %0d, want %0d", got.count, want.count));
        if (got.best_ever !== want.best_ever)
            report_mismatch($sformatf("best ever %0h, want %0h", got.best_ever, want.best_ever));
        if (got.improved !== want.improved)
            report_mismatch($sformatf("improved %0b, want %0b", got.improved, want.improved));
        if (got.iteration !== want.iteration)
            report_mismatch($sformatf("iteration %0d, want %0d", got.iteration, want.iteration));
    endtask

    // result checking, model update on each input transfer and on register writes
    always @(posedge clk) begin
        if (!rst_n) begin
            selector_reset();
            in_taken <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                observed = '{status, neighbor_is_tabu, candidate_index, round_best, round_worst,
                             round_sum, round_count, best_ever, improved, iteration};
                if (due_outcomes.size() == 0) begin
                    report_mismatch("result with nothing outstanding");
                end else begin
                    due = due_outcomes.pop_front();
                    check_result(observed, due);
                end
                result_count++;
                status_tally[observed.status]++;
                if (observed.tabu === 1'b1) tabu_hits++;
                if (observed.improved === 1'b1) improvements++;
            end
            if (cfg_we) depth_reg = cfg_data;
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                due_outcomes.push_back(predict_selection(
                    '{action, fitness, solution_hash, end_of_round}));
                accepted_count++;
            end
        end
    end

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_neighbors.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
                next_neighbor = pending_neighbors.pop_front();
                in_valid      <= 1'b1;
                action        <= next_neighbor.action;
                fitness       <= next_neighbor.fitness;
                solution_hash <= next_neighbor.hash;
                end_of_round  <= next_neighbor.eor;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure, with a long hold-off when asked
    always @(negedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= !steady && ($urandom_range(0, 99) < 35);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_outcomes.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [tns_pkg::FIT_W-1:0] rand_fitness();
        logic [tns_pkg::FIT_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 31'($urandom_range(0, 15));
            1: v = FIT_TOP;
            default: begin
                v = 31'($urandom);
                if (v == tns_pkg::FIT_ONES) v = FIT_TOP;
            end
        endcase
        return v;
    endfunction

    // reuse of recent hashes gives tabu hits
    function automatic logic [tns_pkg::HASH_W-1:0] pick_hash(input int reuse_pct);
        if (recent_hashes.size() != 0 && $urandom_range(0, 99) < reuse_pct)
            return recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
        return $urandom;
    endfunction

    task automatic queue_item(input logic [tns_pkg::ACT_W-1:0] act,
                              input logic [tns_pkg::FIT_W-1:0] fit,
                              input logic [tns_pkg::HASH_W-1:0] h, input logic eor);
        pending_neighbors.push_back('{act, fit, h, eor});
        queued_count++;
        if (act == tns_pkg::ACT_NEIGHBOR || act == tns_pkg::ACT_FALLBACK) begin
            recent_hashes.push_back(h);
            if (recent_hashes.size() > POOL_SIZE) void'(recent_hashes.pop_front());
        end
    endtask

    // mostly complete rounds, some followed by a fallback, plus noise
    task automatic gen_traffic(input int n);
        int made;
        int kind;
        int len;
        logic tabu_round;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
                tabu_round = ($urandom_range(0, 99) < 20);
                for (int k = 0; k < len; k++)
                    queue_item(tns_pkg::ACT_NEIGHBOR, rand_fitness(),
                               pick_hash(tabu_round ? 90 : 25), k == len - 1);
                made += len;
                if ((tabu_round && $urandom_range(0, 99) < 80) || $urandom_range(0, 19) == 0) begin
                    queue_item(tns_pkg::ACT_FALLBACK, rand_fitness(), pick_hash(20),
                               1'($urandom_range(0, 1)));
                    made++;
                end
            end else if (kind < 80) begin
                queue_item(tns_pkg::ACT_FALLBACK, rand_fitness(), pick_hash(30),
                           1'($urandom_range(0, 1)));
            end else if (kind < 87) begin
                queue_item(tns_pkg::ACT_RESTART, rand_fitness(), $urandom,
                           1'($urandom_range(0, 1)));
                made++;
            end else if (kind < 93) begin
                queue_item(ACT_UNUSED, rand_fitness(), $urandom, 1'($urandom_range(0, 1)));
            end else begin
                // stray neighbour, round left open or closed at random
                queue_item(tns_pkg::ACT_NEIGHBOR, rand_fitness(), pick_hash(40),
                           1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (accepted_count != queued_count || due_outcomes.size() != 0);
    endtask

    task automatic write_depth(input logic [tns_pkg::DEPTH_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int k;
        foreach (status_tally[i]) status_tally[i] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every ring entry once with distinct single-neighbour rounds
        for (k = 0; k < 64; k++)
            queue_item(tns_pkg::ACT_NEIGHBOR, rand_fitness(), WARM_KEY + k, 1'b1);
        wait_drained();

        // depth above range, then directed cases
        write_depth(7'd127);
        queue_item(tns_pkg::ACT_RESTART,  FIT_TOP, 32'h0000_0000, 1'b0);
        queue_item(tns_pkg::ACT_NEIGHBOR, '0,      32'h0000_0000, 1'b0);
        queue_item(tns_pkg::ACT_NEIGHBOR, FIT_TOP, 32'hFFFF_FFFF, 1'b1);
        queue_item(tns_pkg::ACT_NEIGHBOR, 31'd7,   32'h0000_0000, 1'b1);   // all forbidden
        queue_item(tns_pkg::ACT_FALLBACK, 31'd3,   32'h0000_00A5, 1'b1);
        queue_item(tns_pkg::ACT_FALLBACK, 31'd1,   32'h0000_0000, 1'b0);   // nobody asked
        queue_item(ACT_UNUSED,            FIT_TOP, 32'hFFFF_FFFF, 1'b1);
        queue_item(tns_pkg::ACT_NEIGHBOR, 31'd9,   32'h0000_0000, 1'b1);   // fallback again
        queue_item(tns_pkg::ACT_NEIGHBOR, 31'd20,  32'h0000_1111, 1'b0);   // drops the request
        queue_item(tns_pkg::ACT_NEIGHBOR, 31'd15,  32'h0000_00A5, 1'b0);
        queue_item(tns_pkg::ACT_NEIGHBOR, 31'd30,  32'h0000_2222, 1'b1);
        queue_item(tns_pkg::ACT_RESTART,  '0,      32'h1234_5678, 1'b1);
        queue_item(tns_pkg::ACT_NEIGHBOR, '0,      32'h0000_3333, 1'b1);
        queue_item(tns_pkg::ACT_FALLBACK, FIT_TOP, 32'hFFFF_FFFF, 1'b1);
        queue_item(tns_pkg::ACT_RESTART,  FIT_TOP, 32'hFFFF_FFFF, 1'b1);
        queue_item(tns_pkg::ACT_NEIGHBOR, FIT_TOP, 32'h5555_AAAA, 1'b0);
        queue_item(tns_pkg::ACT_NEIGHBOR, FIT_TOP - 31'd1, 32'hAAAA_5555, 1'b1);
        queue_item(ACT_UNUSED,            '0,      32'h0000_0000, 1'b0);
        wait_drained();

        write_depth(7'd0);
        gen_traffic(80);
        wait_drained();

        // a burst of short rounds at depth one, receiver held off meanwhile
        write_depth(7'd1);
        queue_item(tns_pkg::ACT_RESTART, rand_fitness(), $urandom, 1'b0);
        for (k = 0; k < BURST_LEN; k++)
            queue_item(tns_pkg::ACT_NEIGHBOR, rand_fitness(), pick_hash(50), k % 4 == 3);
        hold_trigger++;
        wait_drained();

        write_depth(7'd3);
        gen_traffic(110);
        wait_drained();

        write_depth(7'd64);
        steady = 1'b1;
        gen_traffic(110);
        wait_drained();

        write_depth(7'd17);
        steady = 1'b0;
        gen_traffic(70);
        wait_drained();

        repeat (100) @(posedge clk);
        if (due_outcomes.size() != 0) report_mismatch("results never delivered");
        $display(
            "%0d items, %0d results: %0d accepted, %0d fallbacks asked, %0d taken, %0d restarts",
            accepted_count, result_count, status_tally[tns_pkg::STS_ACCEPTED],
            status_tally[tns_pkg::STS_FB_NEEDED], status_tally[tns_pkg::STS_FB_ACCEPTED],
            status_tally[tns_pkg::STS_RESTARTED]);
        $display("%0d tabu hits, %0d improvements, ring depths 64 127 0 1 3 17",
                 tabu_hits, improvements);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/tns_pkg.sv
hdl/tns_ring.sv
hdl/tabu_neighbor_selector_core.sv
test/tb_top.sv
